### hdl/slcm_pkg.sv
`default_nettype none
package slcm_pkg;

  localparam int LINE_BYTES = 64;
  localparam int CNT_W      = $clog2(LINE_BYTES);
  localparam int LEN_W      = 6;
  localparam int ON_LEN     = 6;
  localparam int OFF_LEN    = 7;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  localparam logic FUNC_BYTE    = 1'b0;
  localparam logic FUNC_CONSUME = 1'b1;

  localparam logic [1:0] CMD_NONE    = 2'd0;
  localparam logic [1:0] CMD_LED_ON  = 2'd1;
  localparam logic [1:0] CMD_LED_OFF = 2'd2;

  typedef struct packed {
    logic       func;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [LEN_W-1:0] line_length;
    logic [1:0]       command;
  } out_item_t;

  // Beat held in the input register, handed to the core.
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  function automatic logic [7:0] fold_lower(logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

  function automatic logic [7:0] word_on_char(logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0:    r = 8'h6C; // l
      3'd1:    r = 8'h65; // e
      3'd2:    r = 8'h64; // d
      3'd3:    r = 8'h20;
      3'd4:    r = 8'h6F; // o
      3'd5:    r = 8'h6E; // n
      default: r = 8'h00;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] word_off_char(logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0:    r = 8'h6C; // l
      3'd1:    r = 8'h65; // e
      3'd2:    r = 8'h64; // d
      3'd3:    r = 8'h20;
      3'd4:    r = 8'h6F; // o
      3'd5:    r = 8'h66; // f
      3'd6:    r = 8'h66; // f
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### hdl/serial_line_command_matcher_top.sv
// Serial line command matcher.
// The input channel carries one beat per received character (func = 0) or
// a consume request (func = 1). Characters build a line of up to
// LINE_BYTES - 1 characters; CR or LF ends it, and an LF right after a CR
// is ignored. A consume of a ready line gives one result beat with the
// line length and the command code (led on / led off, case-insensitive);
// a consume with no ready line gives nothing.
// A beat accepted at an edge is held in the input register, and the core
// updates the line state and loads the output register from it once the
// core is not blocked by a waiting result. So a consume beat's result
// passes the input register and then the output register before out_valid
// rises. One beat can be accepted every cycle while no result is held
// back by out_stall; the single pass through the core sets that rate.
// Reset (rst_n low, synchronous) empties the line and clears the ready
// flag and both valid registers. When out_stall holds a waiting result,
// the input register keeps its beat and in_stall rises; one more beat can
// still enter while the input register is empty.
`default_nettype none
module serial_line_command_matcher_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire slcm_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output slcm_pkg::out_item_t      out_item
);
  import slcm_pkg::*;

  stage_t stage;
  logic   blocked;

  slcm_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .blocked  (blocked),
    .stage    (stage)
  );

  slcm_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .stage     (stage),
    .blocked   (blocked),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );
endmodule
`default_nettype wire

### hdl/slcm_in_reg.sv
`default_nettype none
module slcm_in_reg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire slcm_pkg::in_item_t in_item,
  input  wire logic              blocked,
  output slcm_pkg::stage_t       stage
);
  import slcm_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r, item_nxt;

  // The held beat only waits when the core cannot take it this cycle.
  assign in_stall = valid_r && blocked;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (!in_stall) begin
      valid_nxt = in_valid;
      if (in_valid) begin
        item_nxt = in_item;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;
endmodule
`default_nettype wire

### hdl/slcm_core.sv
`default_nettype none
module slcm_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire slcm_pkg::stage_t stage,
  output logic                  blocked,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output slcm_pkg::out_item_t   out_item
);
  import slcm_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             ready_r, ready_nxt;
  logic             last_cr_r, last_cr_nxt;
  logic             on_ok_r, on_ok_nxt;
  logic             off_ok_r, off_ok_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r, out_item_nxt;

  logic             adv;
  logic             load;
  logic [7:0]       c;
  logic [7:0]       fc;
  logic [1:0]       cmd;

  assign blocked = out_valid_r && out_stall;
  assign adv     = stage.valid && !blocked;
  assign c       = stage.item.rx_byte;
  assign fc      = fold_lower(c);
  assign load    = adv && (stage.item.func == FUNC_CONSUME) && ready_r;

  // The line is compared one character at a time as it is stored, so only
  // the length check is left for the consume beat.
  always_comb begin
    priority if (on_ok_r && count_r == CNT_W'(ON_LEN)) begin
      cmd = CMD_LED_ON;
    end else if (off_ok_r && count_r == CNT_W'(OFF_LEN)) begin
      cmd = CMD_LED_OFF;
    end else begin
      cmd = CMD_NONE;
    end
  end

  always_comb begin
    count_nxt    = count_r;
    ready_nxt    = ready_r;
    last_cr_nxt  = last_cr_r;
    on_ok_nxt    = on_ok_r;
    off_ok_nxt   = off_ok_r;
    out_item_nxt = out_item_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (load) begin
      out_valid_nxt            = 1'b1;
      out_item_nxt.line_length = LEN_W'(count_r);
      out_item_nxt.command     = cmd;
      ready_nxt                = 1'b0;
      count_nxt                = '0;
      on_ok_nxt                = 1'b1;
      off_ok_nxt               = 1'b1;
    end else if (adv && stage.item.func == FUNC_BYTE) begin
      last_cr_nxt = (c == CH_CR);
      if (!ready_r) begin
        if (c == CH_CR || c == CH_LF) begin
          // An LF that follows a CR belongs to the line the CR ended.
          if (!(c == CH_LF && last_cr_r)) begin
            ready_nxt = 1'b1;
          end
        end else if (count_r < CNT_W'(LINE_BYTES - 1)) begin
          count_nxt  = count_r + 1'b1;
          on_ok_nxt  = on_ok_r && (count_r >= CNT_W'(ON_LEN) ||
                                   fc == word_on_char(count_r[2:0]));
          off_ok_nxt = off_ok_r && (count_r >= CNT_W'(OFF_LEN) ||
                                    fc == word_off_char(count_r[2:0]));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ready_r     <= 1'b0;
      last_cr_r   <= 1'b0;
      on_ok_r     <= 1'b1;
      off_ok_r    <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ready_r     <= ready_nxt;
      last_cr_r   <= last_cr_nxt;
      on_ok_r     <= on_ok_nxt;
      off_ok_r    <= off_ok_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
endmodule
`default_nettype wire

### tb/tb_top.sv
module tb_top;
  import slcm_pkg::*;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_item   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  serial_line_command_matcher_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pending beats for the driver and the results the line model predicts.
  in_item_t  pending_beats[$];
  out_item_t expected_results[$];
  int        beats_queued   = 0;
  int        mismatch_count = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;

  // Line model state.
  logic [7:0]       line_chars [LINE_BYTES];
  logic [CNT_W-1:0] chars_held = '0;
  logic             line_done  = 1'b0;
  logic             prev_cr    = 1'b0;

  out_item_t want;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic logic line_matches(input string word);
    logic [7:0] c;
    if (chars_held != word.len()) return 1'b0;
    for (int i = 0; i < word.len(); i++) begin
      c = line_chars[i];
      if (c >= "A" && c <= "Z") c = c + 8'd32;
      if (c != word[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic absorb_beat(input in_item_t b);
    logic [1:0] cmd;
    logic       was_cr;
    if (b.func == FUNC_CONSUME) begin
      if (line_done) begin
        cmd = CMD_NONE;
        if (line_matches("led on")) cmd = CMD_LED_ON;
        else if (line_matches("led off")) cmd = CMD_LED_OFF;
        expected_results.push_back(out_item_t'{line_length: LEN_W'(chars_held), command: cmd});
        line_done  = 1'b0;
        chars_held = '0;
      end
    end else begin
      // The CR flag follows every byte, even one dropped while a line waits.
      was_cr  = prev_cr;
      prev_cr = (b.rx_byte == CH_CR);
      if (!line_done) begin
        if (b.rx_byte == CH_CR || b.rx_byte == CH_LF) begin
          if (!(b.rx_byte == CH_LF && was_cr)) line_done = 1'b1;
        end else if (chars_held < LINE_BYTES - 1) begin
          line_chars[chars_held] = b.rx_byte;
          chars_held++;
        end
      end
    end
  endtask

  // Driver: a beat is taken at an edge with valid high and stall low.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) absorb_beat(in_item);
      if (!in_valid || !in_stall) begin
        if (pending_beats.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_item  <= pending_beats.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result len=%0d cmd=%0d with none pending",
                                    out_item.line_length, out_item.command));
        end else begin
          want = expected_results.pop_front();
          if (out_item.line_length !== want.line_length)
            report_mismatch($sformatf("line_length got %0d want %0d",
                                      out_item.line_length, want.line_length));
          if (out_item.command !== want.command)
            report_mismatch($sformatf("command got %0d want %0d",
                                      out_item.command, want.command));
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_beats.push_back(in_item_t'{func: FUNC_BYTE, rx_byte: b});
    beats_queued++;
  endtask

  task automatic push_consume();
    pending_beats.push_back(in_item_t'{func: FUNC_CONSUME, rx_byte: 8'($urandom_range(255))});
    beats_queued++;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  task automatic push_line_end();
    case ($urandom_range(4))
      0: push_byte(CH_CR);
      1: push_byte(CH_LF);
      2: begin
        push_byte(CH_LF);
        push_byte(CH_CR);
      end
      default: begin
        push_byte(CH_CR);
        push_byte(CH_LF);
      end
    endcase
  endtask

  // Command word in random letter case, sometimes altered; not every alteration stops a match.
  task automatic push_command_line(input string word);
    int         flip_at;
    int         drop;
    logic [7:0] c;
    flip_at = ($urandom_range(3) == 0) ? $urandom_range(word.len() - 1) : -1;
    drop    = ($urandom_range(9) == 0) ? 1 : 0;
    for (int i = 0; i < word.len() - drop; i++) begin
      c = word[i];
      if (c >= "a" && c <= "z" && $urandom_range(1)) c = c - 8'd32;
      if (i == flip_at) c = c ^ 8'h20;
      push_byte(c);
    end
    case ($urandom_range(7))
      0: push_byte(8'h00);
      1: push_byte(8'($urandom_range(8'h7E, 8'h20)));
      default: ;
    endcase
  endtask

  task automatic run_random_phase(input int beats_wanted);
    int first;
    int k;
    int n;
    first = beats_queued;
    while (beats_queued - first < beats_wanted) begin
      k = $urandom_range(99);
      if (k < 75) begin
        n = $urandom_range(99);
        if (n < 25) push_command_line("led on");
        else if (n < 50) push_command_line("led off");
        else if (n < 95) repeat ($urandom_range(12)) push_byte(8'($urandom_range(8'h7E, 8'h20)));
        else repeat ($urandom_range(75, 55)) push_byte(8'($urandom_range(8'h7E, 8'h20)));
        push_line_end();
        if ($urandom_range(4) == 0) repeat ($urandom_range(3, 1)) push_byte(8'($urandom_range(255)));
        push_consume();
        if ($urandom_range(9) == 0) push_consume();
      end else if (k < 90) begin
        repeat ($urandom_range(4, 1)) push_byte(8'($urandom_range(255)));
      end else begin
        push_consume();
      end
    end
  endtask

  task automatic drain();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (8) @(negedge clk);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats.
    push_consume();
    push_text("LED ON");
    push_byte(CH_CR);
    push_consume();
    // An LF right after a CR must not make a second, empty line.
    push_byte(CH_LF);
    push_consume();
    push_byte(CH_LF);
    push_consume();
    push_text("Led Off");
    push_byte(CH_LF);
    push_byte("x");
    push_consume();
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_CR);
    push_consume();
    drain();

    send_idle_pct  = 12;
    recv_stall_pct = 74;
    run_random_phase(680);
    drain();

    send_idle_pct  = 74;
    recv_stall_pct = 12;
    run_random_phase(680);
    drain();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random_phase(680);
    drain();

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

### filelist.f
hdl/slcm_pkg.sv
hdl/slcm_in_reg.sv
hdl/slcm_core.sv
hdl/serial_line_command_matcher_top.sv
tb/tb_top.sv
